FILE: rtl/nearest_sample_rate_converter_core_assert.svh
// Assertion macros for the nearest sample rate converter core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef NEAREST_SAMPLE_RATE_CONVERTER_CORE_ASSERT_SVH
`define NEAREST_SAMPLE_RATE_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NSRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nsrc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define NSRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nsrc: next-cycle check failed");

`endif

FILE: rtl/nsrc_pkg.sv
// Shared types and constants for the nearest sample rate converter.
// No dependencies.
`default_nettype none

package nsrc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 13;
  localparam int unsigned PhaseW  = 14;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 13;

  localparam logic [StepW-1:0]  StepMin = 13'd4;
  localparam logic [StepW-1:0]  StepMax = 13'd4096;
  localparam logic [StepW-1:0]  StepRst = 13'd256;
  localparam logic [PhaseW-1:0] UnitQ8  = 14'd256;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_Q8        = 4'd0,
    REG_INPUT_IS_WIDE  = 4'd1,
    REG_OUTPUT_IS_WIDE = 4'd2,
    REG_TWO_CHANNELS   = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    logic [SampleW-1:0] left_raw;
    logic [SampleW-1:0] right_raw;
    logic               final_frame;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic                      run_last;
    logic                      stream_last;
  } out_beat_t;

  // Shared adder result
  typedef struct packed {
    logic [PhaseW-1:0] sum;
    logic              ge_unit;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: rtl/nsrc_fmt.sv
// Sample format conversion: raw byte or word in, signed 16 or 8 bit out.
// Depends on nsrc_pkg.
`default_nettype none

module nsrc_fmt (
  input  wire logic [nsrc_pkg::SampleW-1:0]        raw_i,
  input  wire logic                                input_is_wide_i,
  input  wire logic                                output_is_wide_i,
  output logic signed [nsrc_pkg::SampleW-1:0]      sample_o
);

  logic [nsrc_pkg::SampleW-1:0] dec;

  // Re-center unsigned bytes: (u - 128) << 8 is the byte with its top bit flipped
  always_comb begin
    if (input_is_wide_i) begin
      dec = raw_i;
    end else begin
      dec = {~raw_i[7], raw_i[6:0], 8'h00};
    end
  end

  // Narrow by arithmetic shift right of 8
  always_comb begin
    if (output_is_wide_i) begin
      sample_o = dec;
    end else begin
      sample_o = {{8{dec[15]}}, dec[15:8]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nsrc_phase_alu.sv
// Shared phase adder: accumulates the step or takes one unit off the phase.
// Depends on nsrc_pkg.
`default_nettype none

module nsrc_phase_alu (
  input  wire logic [nsrc_pkg::PhaseW-1:0] phase_i,
  input  wire logic [nsrc_pkg::PhaseW-1:0] operand_i,
  output nsrc_pkg::alu_res_t               res_o
);

  // Add modulo 2^14; flag whether the result reached one whole input
  always_comb begin
    res_o.sum     = phase_i + operand_i;
    res_o.ge_unit = (res_o.sum >= nsrc_pkg::UnitQ8);
  end

endmodule

`default_nettype wire

FILE: rtl/nearest_sample_rate_converter_core.sv
// Nearest-neighbor sample rate converter top level: config, sequencer, output register.
// Depends on nsrc_pkg, nsrc_fmt, nsrc_phase_alu and the assertion macro header.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   input    | in        | in_valid_i/in_stall_o | in_data_i   (nsrc_pkg::in_beat_t)
//   output   | out       | out_valid_o/out_stall_i | out_data_o (nsrc_pkg::out_beat_t)
//   config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An input beat is accepted in the idle state; the run state then makes one output
// per step through the shared phase adder and ends by taking a unit off the phase.
// A stalled output holds the sequencer until the output register frees up.
// Reset (rst_ni low, async) clears the phase, the sequencer, the output valid flag
// and the config registers to their defaults. Config writes are always taken.
`default_nettype none

`include "nearest_sample_rate_converter_core_assert.svh"

module nearest_sample_rate_converter_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire nsrc_pkg::in_beat_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output nsrc_pkg::out_beat_t                   out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [nsrc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [nsrc_pkg::CfgW-1:0]        cfg_data_i
);

  // Config registers
  logic [nsrc_pkg::StepW-1:0] step_cfg_q;
  logic                       in_wide_q, out_wide_q, stereo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cfg_q <= nsrc_pkg::StepRst;
      in_wide_q  <= 1'b1;
      out_wide_q <= 1'b1;
      stereo_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (nsrc_pkg::cfg_reg_e'(cfg_index_i))
        nsrc_pkg::REG_STEP_Q8:        step_cfg_q <= cfg_data_i[nsrc_pkg::StepW-1:0];
        nsrc_pkg::REG_INPUT_IS_WIDE:  in_wide_q  <= cfg_data_i[0];
        nsrc_pkg::REG_OUTPUT_IS_WIDE: out_wide_q <= cfg_data_i[0];
        nsrc_pkg::REG_TWO_CHANNELS:   stereo_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Format both channels of the incoming beat
  logic signed [nsrc_pkg::SampleW-1:0] left_fmt, right_fmt;

  nsrc_fmt u_fmt_left (
    .raw_i            (in_data_i.left_raw),
    .input_is_wide_i  (in_wide_q),
    .output_is_wide_i (out_wide_q),
    .sample_o         (left_fmt)
  );

  nsrc_fmt u_fmt_right (
    .raw_i            (in_data_i.right_raw),
    .input_is_wide_i  (in_wide_q),
    .output_is_wide_i (out_wide_q),
    .sample_o         (right_fmt)
  );

  // Clamp the step into its legal range
  logic [nsrc_pkg::StepW-1:0] step_clamped;

  always_comb begin
    if (step_cfg_q < nsrc_pkg::StepMin) begin
      step_clamped = nsrc_pkg::StepMin;
    end else if (step_cfg_q > nsrc_pkg::StepMax) begin
      step_clamped = nsrc_pkg::StepMax;
    end else begin
      step_clamped = step_cfg_q;
    end
  end

  // Sequencer state and per-beat holding registers
  nsrc_pkg::seq_state_e state_q, state_d;
  logic [nsrc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                        out_valid_q, out_valid_d;
  nsrc_pkg::out_beat_t         out_q;
  logic signed [nsrc_pkg::SampleW-1:0] lval_q, rval_q;
  logic [nsrc_pkg::StepW-1:0]  step_q;
  logic                        fin_q;

  logic in_accept, phase_ge, out_free, emit, wrap;
  logic [nsrc_pkg::PhaseW-1:0] alu_operand;
  nsrc_pkg::alu_res_t          alu_res;

  assign in_accept = in_valid_i && !in_stall_o;
  assign phase_ge  = (phase_q[nsrc_pkg::PhaseW-1:8] != '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  nsrc_phase_alu u_alu (
    .phase_i   (phase_q),
    .operand_i (alu_operand),
    .res_o     (alu_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nsrc_pkg::ST_IDLE: begin
        if (in_accept) state_d = nsrc_pkg::ST_RUN;
      end
      nsrc_pkg::ST_RUN: begin
        if (phase_ge) state_d = nsrc_pkg::ST_IDLE;
      end
      default: state_d = nsrc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    emit        = 1'b0;
    wrap        = 1'b0;
    alu_operand = nsrc_pkg::PhaseW'(step_q);
    case (state_q)
      nsrc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      nsrc_pkg::ST_RUN: begin
        if (phase_ge) begin
          wrap        = 1'b1;
          alu_operand = -nsrc_pkg::UnitQ8;
        end else begin
          emit = out_free;
        end
      end
      default: ;
    endcase
  end

  // Advance the phase: add the step per output, drop one unit at the end, or clear it after a final frame
  always_comb begin
    phase_d = phase_q;
    if (emit) begin
      phase_d = alu_res.sum;
    end else if (wrap) begin
      phase_d = fin_q ? '0 : alu_res.sum;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nsrc_pkg::ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the formatted samples and step of the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lval_q <= left_fmt;
      rval_q <= stereo_q ? right_fmt : '0;
      step_q <= step_clamped;
      fin_q  <= in_data_i.final_frame;
    end
  end

  // Load the output register with one beat per emitted frame
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.left_out    <= lval_q;
      out_q.right_out   <= rval_q;
      out_q.run_last    <= alu_res.ge_unit;
      out_q.stream_last <= alu_res.ge_unit && fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NSRC_ASSERT_NOW(a_stream_last_ends_run, out_valid_o, !out_data_o.stream_last || out_data_o.run_last)
  `NSRC_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o)
  `NSRC_ASSERT_NEXT(a_final_clears_phase, wrap && fin_q, phase_q == '0)
  `NSRC_ASSERT_NOW(a_idle_phase_bounded, state_q == nsrc_pkg::ST_IDLE, phase_q < 14'd4096)
  `NSRC_ASSERT_NOW(a_emit_needs_room, emit, out_free && !phase_ge)

endmodule

`default_nettype wire
